// ===== rtl/core/fbcp_pkg.sv =====
package fbcp_pkg;

	localparam int unsigned CodeBits = 5;
	localparam int unsigned ByteBits = 8;
	localparam int unsigned PendBits = 7;

	localparam logic [7:0] CharA     = 8'h41;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharQuery = 8'h3F;
	localparam logic [7:0] CharFour  = 8'h34;
	localparam logic [7:0] CharSix   = 8'h36;
	localparam logic [7:0] CharEight = 8'h38;
	localparam logic [7:0] CharNine  = 8'h39;

	localparam logic [4:0] CodeSpace = 5'd26;
	localparam logic [4:0] CodeQuery = 5'd27;
	localparam logic [4:0] CodeFour  = 5'd28;
	localparam logic [4:0] CodeSix   = 5'd29;
	localparam logic [4:0] CodeEight = 5'd30;
	localparam logic [4:0] CodeNine  = 5'd31;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	function automatic logic [4:0] char_code(input logic [7:0] ch);
		logic [7:0] diff;
		diff = ch - CharA;
		unique case (ch)
			CharSpace: char_code = CodeSpace;
			CharQuery: char_code = CodeQuery;
			CharFour:  char_code = CodeFour;
			CharSix:   char_code = CodeSix;
			CharEight: char_code = CodeEight;
			CharNine:  char_code = CodeNine;
			default:   char_code = diff[4:0];
		endcase
	endfunction

endpackage

// ===== rtl/core/five_bit_char_packer.sv =====
// Five-bit character packer. Each input beat carries one character, which is
// mapped to a 5-bit code and appended MSB first to a continuous bit stream;
// every byte that fills up leaves as one output beat. A beat with final_char
// set flushes the leftover bits as a zero-padded byte, and the last byte of
// the message carries final_byte. The block takes one character per cycle
// while in_stall is low and emits one byte per cycle while out_stall is low;
// a character is registered first, then its byte passes through the 2-entry
// output queue. An input beat that yields two bytes (a final flush after a
// full byte) waits in the input register until the output queue is empty.
module five_bit_char_packer
	import fbcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] packed_byte,
	output logic       final_byte
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;

	logic [PendBits-1:0] pend_bits_q;
	logic [2:0]          pend_cnt_q;

	out_beat_t  fifo_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] fifo_cnt_q;

	logic [4:0]  code;
	logic [11:0] acc;
	logic [3:0]  cnt_sum;
	logic        full;
	logic [2:0]  rest;
	logic [11:0] acc_shr;
	logic [11:0] rem_mask;
	logic [PendBits-1:0] rem;
	logic [2:0]  cnt_after;
	logic [14:0] flush_shl;
	logic [2:0]  flush_amt;
	logic        do_flush;
	logic [1:0]  n_push;
	logic [1:0]  n_free;
	logic        adv;
	logic        pop;
	out_beat_t   beat0;
	out_beat_t   beat1;

	always_comb begin
		code      = char_code(char_s1);
		acc       = {pend_bits_q, code};
		cnt_sum   = {1'b0, pend_cnt_q} + 4'(CodeBits);
		full      = cnt_sum >= 4'(ByteBits);
		rest      = 3'(cnt_sum - 4'(ByteBits));
		acc_shr   = acc >> rest;
		rem_mask  = (12'd1 << rest) - 12'd1;
		cnt_after = full ? rest : cnt_sum[2:0];
		rem       = full ? PendBits'(acc & rem_mask) : acc[PendBits-1:0];
		flush_amt = 3'(4'(ByteBits) - {1'b0, cnt_after});
		flush_shl = {8'd0, rem} << flush_amt;
		do_flush  = final_s1 && (cnt_after != 3'd0);
		n_push    = {1'b0, full} + {1'b0, do_flush};

		beat0.data = full ? acc_shr[7:0] : flush_shl[7:0];
		beat0.last = full ? (final_s1 && !do_flush) : 1'b1;
		beat1.data = flush_shl[7:0];
		beat1.last = 1'b1;

		n_free   = 2'd2 - fifo_cnt_q;
		adv      = valid_s1 && (n_free >= n_push);
		in_stall = valid_s1 && !adv;
		pop      = out_valid && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1  <= char_byte;
			final_s1 <= final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (adv) begin
			if (final_s1) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= rem;
				pend_cnt_q  <= cnt_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= beat0;
		end
		if (adv && n_push == 2'd2) begin
			fifo_q[~wr_ptr_q] <= beat1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= 1'b0;
			wr_ptr_q   <= 1'b0;
			fifo_cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (adv) begin
				wr_ptr_q <= wr_ptr_q ^ n_push[0];
			end
			fifo_cnt_q <= fifo_cnt_q + (adv ? n_push : 2'd0) - {1'b0, pop};
		end
	end

	assign out_valid   = fifo_cnt_q != 2'd0;
	assign packed_byte = fifo_q[rd_ptr_q].data;
	assign final_byte  = fifo_q[rd_ptr_q].last;

	// every input beat leaves at least one byte when final
	a_final_push: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && final_s1) |-> (n_push != 2'd0))
		else $error("final beat produced no byte");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && final_s1) |=> (pend_cnt_q == 3'd0))
		else $error("pending bits survive a final beat");

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= 2'd2)
		else $error("output queue overflow");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_cnt_q == 2'd1) |-> (rd_ptr_q != wr_ptr_q))
		else $error("queue pointers disagree with count");

endmodule
